// ===== hdl/trn_pkg.sv =====
package trn_pkg;

   localparam int COORD_BITS_DEF       = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   // magnitude kept for the length computation
   localparam int MANT_BITS     = 24;
   localparam int ROOT_PRESHIFT = 12;
   localparam int ROOT_FRAC     = 6;

   localparam int SUM_BITS  = 2 * MANT_BITS + 2;
   localparam int RAD_BITS  = SUM_BITS + ROOT_PRESHIFT;
   localparam int ROOT_BITS = RAD_BITS / 2;

   typedef logic [MANT_BITS-1:0] mant_type;
   typedef logic [RAD_BITS-1:0]  rad_type;
   typedef logic [ROOT_BITS-1:0] root_type;

endpackage

// ===== hdl/trn_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module trn_isqrt (
   input  logic               clock,
   input  logic               en,
   input  trn_pkg::rad_type   rad,
   output trn_pkg::root_type  root
);

   localparam int RB   = trn_pkg::ROOT_BITS;
   localparam int XB   = trn_pkg::RAD_BITS;
   localparam int REMW = RB + 3;

   logic [XB-1:0]   x_ff    [RB];
   logic [REMW-1:0] rem_ff  [RB];
   logic [RB-1:0]   root_ff [RB];

   for (genvar k = 0; k < RB; k++) begin : g_stage
      logic [XB-1:0]   x_cur;
      logic [REMW-1:0] rem_cur;
      logic [RB-1:0]   root_cur;
      logic [REMW-1:0] rem_sh;
      logic [REMW-1:0] trial;
      logic [XB-1:0]   x_in;
      logic [REMW-1:0] rem_in;
      logic [RB-1:0]   root_in;

      if (k == 0) begin : g_first
         assign x_cur    = rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign x_cur    = x_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_cur[REMW-3:0], x_cur[XB-1 -: 2]};
         trial  = {1'b0, root_cur, 2'b01};
         x_in   = {x_cur[XB-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_cur[RB-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_cur[RB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[RB-1];

endmodule

// ===== hdl/trn_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module trn_div #(
   parameter int NUM_W = 46,
   parameter int DEN_W = 32,
   parameter int Q_W   = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   localparam int REMW = DEN_W + Q_W;

   logic [REMW-1:0]  rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic [REMW-1:0]  rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [Q_W-1:0]   q_cur;
      logic [REMW-1:0]  trial;
      logic [REMW-1:0]  rem_in;
      logic [Q_W-1:0]   q_in;

      if (j == 0) begin : g_first
         assign rem_cur = REMW'(num);
         assign den_cur = den;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign den_cur = den_ff[j-1];
         assign q_cur   = q_ff[j-1];
      end

      always_comb begin
         trial = REMW'(den_cur) << (Q_W - 1 - j);
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            q_in   = {q_cur[Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_cur;
            q_in   = {q_cur[Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_cur;
            q_ff[j]   <= q_in;
         end
      end
   end

   assign quo = q_ff[Q_W-1];

endmodule

// ===== hdl/triangle_unit_normal.sv =====
// Unit face normal of one triangle per clock. A transaction carries three vertices; the
// block returns (v2-v0) x (v1-v0) scaled to unit length in signed fixed point with
// NORMAL_FRAC_BITS fraction bits, rounded to nearest, and flags a zero-area triangle in
// rsp_tuser with a zero normal. It is a fully pipelined datapath with no state between
// triangles: one triangle enters every cycle unless the pipeline is frozen, the square root
// taking one root bit per stage and the three dividers one quotient bit per stage. A result
// held by rsp_tready low freezes the whole pipeline, and the input with it.
module triangle_unit_normal #(
   parameter int COORD_BITS       = trn_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = trn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
   input  logic [((9*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic rsp_tuser
);

   localparam int CB   = COORD_BITS;
   localparam int NB   = NORMAL_FRAC_BITS + 2;
   localparam int EW   = CB + 1;
   localparam int PW   = 2 * CB + 2;
   localparam int NW   = 2 * CB + 3;
   localparam int MW   = 2 * CB + 2;
   localparam int MB   = trn_pkg::MANT_BITS;
   localparam int SHW  = (MW > MB) ? $clog2(MW - MB + 1) : 1;
   localparam int RB   = trn_pkg::ROOT_BITS;
   localparam int QW   = NB;
   localparam int NUMW = MB + NORMAL_FRAC_BITS + trn_pkg::ROOT_FRAC + 2;
   localparam int DENW = RB + 1;
   localparam int LAT  = 10 + RB + QW;
   localparam int OUTW = ((3 * NB + 7) / 8) * 8;

   logic en;
   logic [LAT-1:0] valid_ff;

   assign en         = rsp_tready | ~valid_ff[LAT-1];
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   // edges
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   for (genvar k = 0; k < 3; k++) begin : g_edge
      logic signed [CB-1:0] p0, p1, p2;
      assign p0 = req_tdata[k*CB +: CB];
      assign p1 = req_tdata[(3+k)*CB +: CB];
      assign p2 = req_tdata[(6+k)*CB +: CB];
      always_ff @(posedge clock) begin
         if (en) begin
            e1_ff[k] <= EW'(p1) - EW'(p0);
            e2_ff[k] <= EW'(p2) - EW'(p0);
         end
      end
   end

   // cross product terms, n_i = pa_i - pb_i
   logic signed [PW-1:0] pa_ff [3];
   logic signed [PW-1:0] pb_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff[0] <= PW'(e2_ff[1]) * PW'(e1_ff[2]);
         pb_ff[0] <= PW'(e2_ff[2]) * PW'(e1_ff[1]);
         pa_ff[1] <= PW'(e2_ff[2]) * PW'(e1_ff[0]);
         pb_ff[1] <= PW'(e2_ff[0]) * PW'(e1_ff[2]);
         pa_ff[2] <= PW'(e2_ff[0]) * PW'(e1_ff[1]);
         pb_ff[2] <= PW'(e2_ff[1]) * PW'(e1_ff[0]);
      end
   end

   logic signed [NW-1:0] n_ff [3];
   logic [MW-1:0] mag_ff [3];
   logic [3:0]    side_ff [LAT-4];   // {degenerate, sign_z, sign_y, sign_x}
   logic [3:0]    side_in;
   logic [NW-1:0] neg_n [3];

   for (genvar k = 0; k < 3; k++) begin : g_mag
      assign neg_n[k] = -n_ff[k];
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]   <= NW'(pa_ff[k]) - NW'(pb_ff[k]);
            mag_ff[k] <= n_ff[k][NW-1] ? neg_n[k][MW-1:0] : n_ff[k][MW-1:0];
         end
      end
   end

   assign side_in = {(n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0),
                     n_ff[2][NW-1], n_ff[1][NW-1], n_ff[0][NW-1]};

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT - 4; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // block shift so the largest magnitude fits the mantissa
   logic [MW-1:0]  mag_or;
   logic [SHW-1:0] sh_in;
   logic [SHW-1:0] sh_ff;
   logic [MW-1:0]  mag2_ff [3];

   assign mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];

   always_comb begin
      sh_in = '0;
      for (int i = MB; i < MW; i++) begin
         if (mag_or[i]) begin
            sh_in = SHW'(i - MB + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff <= sh_in;
         for (int k = 0; k < 3; k++) begin
            mag2_ff[k] <= mag_ff[k];
         end
      end
   end

   logic [2*MB-1:0] sq_ff [3];
   trn_pkg::rad_type rad_ff;
   logic [MW-1:0] shifted [3];

   for (genvar k = 0; k < 3; k++) begin : g_shift
      assign shifted[k] = mag2_ff[k] >> sh_ff;
   end

   // per-component mantissa delay line to meet the root at the divider inputs
   trn_pkg::mant_type ac_ff [3][RB+3];
   for (genvar k = 0; k < 3; k++) begin : g_adly
      always_ff @(posedge clock) begin
         if (en) begin
            ac_ff[k][0] <= MB'(shifted[k]);
            for (int i = 1; i < RB + 3; i++) begin
               ac_ff[k][i] <= ac_ff[k][i-1];
            end
            sq_ff[k] <= (2*MB)'(ac_ff[k][0]) * (2*MB)'(ac_ff[k][0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= {trn_pkg::SUM_BITS'(sq_ff[0]) + trn_pkg::SUM_BITS'(sq_ff[1])
                    + trn_pkg::SUM_BITS'(sq_ff[2]), trn_pkg::ROOT_PRESHIFT'(0)};
      end
   end

   trn_pkg::root_type root;

   trn_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   logic [NUMW-1:0] num_ff [3];
   logic [DENW-1:0] den_ff;
   logic [QW-1:0]   quo [3];
   logic [NB-1:0]   norm_ff [3];
   logic            degen_ff;

   for (genvar k = 0; k < 3; k++) begin : g_div
      logic [NB-1:0] qs;

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k] <= (NUMW'(ac_ff[k][RB+2]) << (NORMAL_FRAC_BITS + trn_pkg::ROOT_FRAC + 1))
                         + NUMW'(root);
         end
      end

      trn_div #(
         .NUM_W (NUMW),
         .DEN_W (DENW),
         .Q_W   (QW)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[k]),
         .den   (den_ff),
         .quo   (quo[k])
      );

      // saturate to one, then zero a degenerate result or apply the sign
      always_comb begin
         qs = (quo[k] > (QW'(1) << NORMAL_FRAC_BITS)) ? (NB'(1) << NORMAL_FRAC_BITS) : quo[k];
         if (side_ff[LAT-5][3]) begin
            qs = '0;
         end else if (side_ff[LAT-5][k]) begin
            qs = -qs;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            norm_ff[k] <= qs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff   <= {root, 1'b0};
         degen_ff <= side_ff[LAT-5][3];
      end
   end

   assign rsp_tdata = OUTW'({norm_ff[2], norm_ff[1], norm_ff[0]});
   assign rsp_tuser = degen_ff;

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[3*NB-1:0] == '0)
      else $error("degenerate result with nonzero normal");

   a_unit_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[3*NB-1:0] != '0)
      else $error("non-degenerate result with zero normal");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== dv/triangle_unit_normal_tb.sv =====
module triangle_unit_normal_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = trn_pkg::COORD_BITS_DEF;
   localparam int FB = trn_pkg::NORMAL_FRAC_BITS_DEF;
   localparam int NB = FB + 2;
   localparam int IN_W = ((9*CB+7)/8)*8;
   localparam int OUT_W = ((3*NB+7)/8)*8;

   typedef struct packed {
      logic [NB-1:0] nz;
      logic [NB-1:0] ny;
      logic [NB-1:0] nx;
      logic          degen;
   } normal_type;

   // exact integer root of a 64-bit value
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic normal_type face_normal(logic [IN_W-1:0] tri_bits);
      longint p [9];
      longint e1 [3], e2 [3], n [3];
      longint unsigned a [3], m, ssum, root, num, q;
      int sh;
      normal_type r;
      for (int i = 0; i < 9; i++) p[i] = longint'($signed(tri_bits[i*CB +: CB]));
      for (int k = 0; k < 3; k++) begin
         e1[k] = p[3+k] - p[k];
         e2[k] = p[6+k] - p[k];
      end
      n[0] = e2[1]*e1[2] - e2[2]*e1[1];
      n[1] = e2[2]*e1[0] - e2[0]*e1[2];
      n[2] = e2[0]*e1[1] - e2[1]*e1[0];
      r = '0;
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
         r.degen = 1'b1;
         return r;
      end
      m = 0;
      for (int k = 0; k < 3; k++) begin
         a[k] = n[k] < 0 ? -n[k] : n[k];
         if (a[k] > m) m = a[k];
      end
      sh = 0;
      while ((m >> sh) >= (64'd1 << trn_pkg::MANT_BITS)) sh++;
      ssum = 0;
      for (int k = 0; k < 3; k++) begin
         a[k] = a[k] >> sh;
         ssum += a[k]*a[k];
      end
      root = int_sqrt(ssum << trn_pkg::ROOT_PRESHIFT);
      for (int k = 0; k < 3; k++) begin
         num = a[k] << (FB + trn_pkg::ROOT_FRAC + 1);
         q = (num + root) / (2*root);
         if (q > (64'd1 << FB)) q = 64'd1 << FB;
         if (n[k] < 0) q = -q;
         if (k == 0) r.nx = q[NB-1:0];
         else if (k == 1) r.ny = q[NB-1:0];
         else r.nz = q[NB-1:0];
      end
      return r;
   endfunction

   class normal_scoreboard;
      normal_type pending [$];
      int errors = 0;
      function void note_triangle(logic [IN_W-1:0] t);
         pending = {pending, face_normal(t)};
      endfunction
      function void check_normal(logic [OUT_W-1:0] d, logic u);
         normal_type got, exp_n;
         got.nx = d[0 +: NB];
         got.ny = d[NB +: NB];
         got.nz = d[2*NB +: NB];
         got.degen = u;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         exp_n = pending.pop_front();
         if (got.nx !== exp_n.nx) begin
            $display("%0t: normal_x exp %h got %h", $realtime, exp_n.nx, got.nx); errors++;
         end
         if (got.ny !== exp_n.ny) begin
            $display("%0t: normal_y exp %h got %h", $realtime, exp_n.ny, got.ny); errors++;
         end
         if (got.nz !== exp_n.nz) begin
            $display("%0t: normal_z exp %h got %h", $realtime, exp_n.nz, got.nz); errors++;
         end
         if (got.degen !== exp_n.degen) begin
            $display("%0t: degenerate exp %b got %b", $realtime, exp_n.degen, got.degen);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0;
   logic req_tready, rsp_tvalid, rsp_tuser;
   logic [IN_W-1:0] req_tdata = '0;
   logic [OUT_W-1:0] rsp_tdata;
   normal_scoreboard sb = new();
   bit sending_done = 0;
   bit hurry = 0;

   triangle_unit_normal dut (.*);

   initial forever #4 clock = ~clock;

   task automatic send_triangle(logic [IN_W-1:0] t);
      int gap;
      gap = hurry ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= t;
      do @(posedge clock); while (!req_tready);
      sb.note_triangle(t);
   endtask

   function automatic logic [IN_W-1:0] pack_tri(int c [9]);
      logic [IN_W-1:0] t;
      t = '0;
      for (int i = 0; i < 9; i++) t[i*CB +: CB] = c[i][CB-1:0];
      return t;
   endfunction

   function automatic logic [IN_W-1:0] random_tri();
      logic [IN_W-1:0] t;
      int c [9];
      int span, mode;
      mode = $urandom_range(0, 9);
      t = '0;
      if (mode < 2) begin
         for (int i = 0; i < 9; i++) t[i*CB +: CB] = CB'($urandom);
         return t;
      end
      span = (mode < 5) ? 256 : (mode < 8 ? 4096 : 32767);
      for (int i = 0; i < 9; i++) c[i] = $urandom_range(0, 2*span) - span;
      if (mode == 9) begin
         // collinear: v2 on the line through v0 and v1, unless a coordinate is wrapped into range
         for (int k = 0; k < 3; k++) c[6+k] = c[k] + 2*(c[3+k] - c[k]);
         for (int k = 0; k < 9; k++) if (c[k] > 32767 || c[k] < -32768) c[k] = c[k] % 32768;
      end
      return pack_tri(c);
   endfunction

   // result side
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = hurry ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_normal(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int c [9];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      c = '{0,0,0, 0,0,0, 0,0,0};  send_triangle(pack_tri(c));
      c = '{0,0,0, 1,0,0, 0,1,0};  send_triangle(pack_tri(c));
      c = '{0,0,0, 0,1,0, 1,0,0};  send_triangle(pack_tri(c));
      c = '{0,0,0, 0,0,1, 0,1,0};  send_triangle(pack_tri(c));
      c = '{0,0,0, 1,1,1, 2,2,2};  send_triangle(pack_tri(c));
      c = '{-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768};
      send_triangle(pack_tri(c));
      c = '{32767,32767,32767, -32768,32767,32767, 32767,-32768,32767};
      send_triangle(pack_tri(c));
      c = '{-32768,32767,-32768, 32767,-32768,32767, -32768,-32768,32767};
      send_triangle(pack_tri(c));
      c = '{32767,-32768,0, -32768,0,32767, 0,32767,-32768};
      send_triangle(pack_tri(c));
      c = '{-1,-1,-1, -1,-1,-1, -1,-1,-1};  send_triangle(pack_tri(c));
      c = '{5,5,5, 6,5,5, 5,5,5};  send_triangle(pack_tri(c));
      c = '{0,0,0, 1,2,3, -3,1,2};  send_triangle(pack_tri(c));
      c = '{0,0,0, 1,1,0, 1,0,1};  send_triangle(pack_tri(c));
      c = '{0,0,0, 3,0,0, 0,4,1};  send_triangle(pack_tri(c));
      c = '{100,-200,300, -32768,32767,1, 7,-9,32767};  send_triangle(pack_tri(c));
      for (int i = 0; i < 1600; i++) begin
         if (i == 800) hurry = 1;
         if (i == 1000) hurry = 0;
         send_triangle(random_tri());
      end
      req_tvalid <= 1'b0;
      sending_done = 1;
   end

   initial begin
      wait (sending_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #3ms;
      $display("simulation failed");
      $finish;
   end
endmodule
